// File: sv/rounded_percent_divider_assert.svh
// assertion macros for the rounded percent divider
`ifndef ROUNDED_PERCENT_DIVIDER_ASSERT_SVH
`define ROUNDED_PERCENT_DIVIDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rpd_pkg.sv
// constants shared by the rounded percent divider modules
`timescale 1ns / 1ps

package rpd_pkg;

   // percentage scale and the bits it adds to the dividend
   localparam int PERCENT_SCALE = 100;
   localparam int SCALE_BITS = 7;

   // result limit register
   localparam int LIMIT_WIDTH = 31;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

   // value reported for a zero total before clamping
   localparam int ZERO_TOTAL_VALUE = 100;

endpackage

// File: sv/rpd_prep.sv
// input stage: builds the rounded dividend 100*part + total/2
`timescale 1ns / 1ps

module rpd_prep #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COUNT_WIDTH-1:0] in_part,
   input  logic [COUNT_WIDTH-1:0] in_total,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [COUNT_WIDTH+rpd_pkg::SCALE_BITS-1:0] out_dividend,
   output logic [COUNT_WIDTH-1:0] out_divisor,
   output logic                   out_zero
);

   localparam int QUOT_WIDTH = COUNT_WIDTH + rpd_pkg::SCALE_BITS;

   logic                   valid_ff;
   logic                   valid_in;
   logic [QUOT_WIDTH-1:0]  dividend_ff;
   logic [QUOT_WIDTH-1:0]  dividend_in;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic                   zero_ff;
   logic                   zero_in;

   // stage can load when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // scaled part plus half the total, never wraps in this width
   assign dividend_in = QUOT_WIDTH'(in_part) * QUOT_WIDTH'(rpd_pkg::PERCENT_SCALE)
                      + QUOT_WIDTH'(in_total >> 1);
   assign zero_in = (in_total == '0);

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= in_total;
         zero_ff     <= zero_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_dividend = dividend_ff;
   assign out_divisor  = divisor_ff;
   assign out_zero     = zero_ff;

endmodule

// File: sv/rpd_div_stage.sv
// one restoring division step: settles one quotient bit per stage
`timescale 1ns / 1ps

module rpd_div_stage #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COUNT_WIDTH-1:0] in_rem,
   input  logic [COUNT_WIDTH+rpd_pkg::SCALE_BITS-1:0] in_shift,
   input  logic [COUNT_WIDTH-1:0] in_divisor,
   input  logic                   in_zero,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [COUNT_WIDTH-1:0] out_rem,
   output logic [COUNT_WIDTH+rpd_pkg::SCALE_BITS-1:0] out_shift,
   output logic [COUNT_WIDTH-1:0] out_divisor,
   output logic                   out_zero
);

   localparam int QUOT_WIDTH = COUNT_WIDTH + rpd_pkg::SCALE_BITS;

   logic                   valid_ff;
   logic                   valid_in;
   logic [COUNT_WIDTH:0]   trial;
   logic [COUNT_WIDTH:0]   diff;
   logic                   take;
   logic [COUNT_WIDTH-1:0] rem_ff;
   logic [COUNT_WIDTH-1:0] rem_in;
   logic [QUOT_WIDTH-1:0]  shift_ff;
   logic [QUOT_WIDTH-1:0]  shift_in;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic                   zero_ff;

   // stage can load when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // bring down the next dividend bit and try the subtract
   // trial is below twice a nonzero divisor, so the borrow bit alone decides
   assign trial = {in_rem, in_shift[QUOT_WIDTH-1]};
   assign diff  = trial - {1'b0, in_divisor};
   assign take  = !diff[COUNT_WIDTH];

   // remainder stays below a nonzero divisor either way
   assign rem_in   = take ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
   assign shift_in = {in_shift[QUOT_WIDTH-2:0], take};

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff     <= rem_in;
         shift_ff   <= shift_in;
         divisor_ff <= in_divisor;
         zero_ff    <= in_zero;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rem     = rem_ff;
   assign out_shift   = shift_ff;
   assign out_divisor = divisor_ff;
   assign out_zero    = zero_ff;

endmodule

// File: sv/rpd_clamp.sv
// output stage: zero-total override, saturation at the limit, result register
`timescale 1ns / 1ps

module rpd_clamp #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COUNT_WIDTH+rpd_pkg::SCALE_BITS-1:0] in_quotient,
   input  logic                   in_zero,
   input  logic [rpd_pkg::LIMIT_WIDTH-1:0] limit,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [rpd_pkg::LIMIT_WIDTH-1:0] out_percent,
   output logic                   out_clamped
);

   localparam int QUOT_WIDTH = COUNT_WIDTH + rpd_pkg::SCALE_BITS;
   localparam int CMP_WIDTH =
      (QUOT_WIDTH > rpd_pkg::LIMIT_WIDTH) ? QUOT_WIDTH : rpd_pkg::LIMIT_WIDTH;

   logic                            valid_ff;
   logic                            valid_in;
   logic [CMP_WIDTH-1:0]            value_ext;
   logic [CMP_WIDTH-1:0]            limit_ext;
   logic                            clamped_in;
   logic [rpd_pkg::LIMIT_WIDTH-1:0] percent_in;
   logic [rpd_pkg::LIMIT_WIDTH-1:0] percent_ff;
   logic                            clamped_ff;

   // output register frees as soon as the result is taken
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // exact value, with a zero total standing for a full hundred
   assign value_ext = in_zero ? CMP_WIDTH'(rpd_pkg::ZERO_TOTAL_VALUE)
                              : CMP_WIDTH'(in_quotient);
   assign limit_ext = CMP_WIDTH'(limit);

   // saturate at the limit
   assign clamped_in = (value_ext > limit_ext);
   assign percent_in = clamped_in ? limit : value_ext[rpd_pkg::LIMIT_WIDTH-1:0];

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         percent_ff <= percent_in;
         clamped_ff <= clamped_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_percent = percent_ff;
   assign out_clamped = clamped_ff;

endmodule

// File: sv/rounded_percent_divider.sv
// Rounded percent divider, top level.
// Takes a part count and a total count on the req_ channel and returns
// floor((100*part + floor(total/2)) / total) on the rsp_ channel, saturated
// at the result limit; rsp_was_clamped marks a saturated result. A zero
// total gives 100, saturated the same way.
// The limit is written through csr_write_enable / csr_write_data; the user
// must see that it only changes while no transaction is in flight, which
// the block itself does not enforce. A request passes through the dividend
// register, the divider pipeline with one quotient bit per stage
// (COUNT_WIDTH + 7 stages) and the saturating output register on its way
// to rsp_valid. Throughput: one transaction per cycle while rsp_ready stays
// high; every divider stage holds its own item with a valid bit.
// Reset clears every valid bit and loads the limit with 2^31 - 1.
// When the receiver stalls, the result stays in the output register and
// the stages behind it keep filling any empty slots; req_ready falls only
// once every stage holds a transaction.
`timescale 1ns / 1ps

`include "rounded_percent_divider_assert.svh"

module rounded_percent_divider #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [COUNT_WIDTH-1:0]          req_part_count,
   input  logic [COUNT_WIDTH-1:0]          req_total_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rpd_pkg::LIMIT_WIDTH-1:0] rsp_percent_value,
   output logic                            rsp_was_clamped,
   input  logic                            csr_write_enable,
   input  logic [rpd_pkg::LIMIT_WIDTH-1:0] csr_write_data
);

   localparam int QUOT_WIDTH = COUNT_WIDTH + rpd_pkg::SCALE_BITS;

   logic [rpd_pkg::LIMIT_WIDTH-1:0] result_limit_ff;
   logic [rpd_pkg::LIMIT_WIDTH-1:0] result_limit_in;

   // stage 0 is the dividend register, stages 1..QUOT_WIDTH the divider
   logic                   stage_valid   [0:QUOT_WIDTH];
   logic                   stage_ready   [0:QUOT_WIDTH];
   logic [COUNT_WIDTH-1:0] stage_rem     [0:QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0]  stage_shift   [0:QUOT_WIDTH];
   logic [COUNT_WIDTH-1:0] stage_divisor [0:QUOT_WIDTH];
   logic                   stage_zero    [0:QUOT_WIDTH];

   // limit register
   assign result_limit_in = csr_write_enable ? csr_write_data : result_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         result_limit_ff <= rpd_pkg::LIMIT_RESET;
      end else begin
         result_limit_ff <= result_limit_in;
      end
   end

   // dividend formation
   rpd_prep #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_part      (req_part_count),
      .in_total     (req_total_count),
      .out_valid    (stage_valid[0]),
      .out_ready    (stage_ready[0]),
      .out_dividend (stage_shift[0]),
      .out_divisor  (stage_divisor[0]),
      .out_zero     (stage_zero[0])
   );

   // partial remainder starts at zero
   assign stage_rem[0] = '0;

   // divider pipeline, one quotient bit per stage
   for (genvar i = 1; i <= QUOT_WIDTH; i++) begin : g_div
      rpd_div_stage #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (stage_valid[i-1]),
         .in_ready    (stage_ready[i-1]),
         .in_rem      (stage_rem[i-1]),
         .in_shift    (stage_shift[i-1]),
         .in_divisor  (stage_divisor[i-1]),
         .in_zero     (stage_zero[i-1]),
         .out_valid   (stage_valid[i]),
         .out_ready   (stage_ready[i]),
         .out_rem     (stage_rem[i]),
         .out_shift   (stage_shift[i]),
         .out_divisor (stage_divisor[i]),
         .out_zero    (stage_zero[i])
      );
   end

   // saturation and result register
   rpd_clamp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_clamp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid[QUOT_WIDTH]),
      .in_ready    (stage_ready[QUOT_WIDTH]),
      .in_quotient (stage_shift[QUOT_WIDTH]),
      .in_zero     (stage_zero[QUOT_WIDTH]),
      .limit       (result_limit_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_percent (rsp_percent_value),
      .out_clamped (rsp_was_clamped)
   );

   // a saturated result carries exactly the limit
   `RPD_ASSERT_IMPLY(a_clamped_is_limit, clock, reset,
      rsp_valid && rsp_was_clamped, rsp_percent_value == result_limit_ff,
      "saturated result differs from the limit")

   // an unsaturated result never exceeds the limit
   `RPD_ASSERT_IMPLY(a_unclamped_in_range, clock, reset,
      rsp_valid && !rsp_was_clamped, rsp_percent_value <= result_limit_ff,
      "unsaturated result above the limit")

   // an accepted request always lands in the dividend stage
   `RPD_ASSERT_NEXT(a_request_enters, clock, reset,
      req_valid && req_ready, stage_valid[0],
      "accepted request missing from the dividend stage")

endmodule

// File: sim/rounded_percent_divider_tb.sv
// self-checking testbench for the rounded percent divider
`timescale 1ns / 1ps

module rounded_percent_divider_tb;

   localparam int COUNT_WIDTH = 32;
   localparam int LIMIT_WIDTH = rpd_pkg::LIMIT_WIDTH;
   localparam int RESULT_LATENCY = COUNT_WIDTH + 9;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 238;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = rpd_pkg::LIMIT_RESET;
   localparam logic [LIMIT_WIDTH-1:0] ZERO_VALUE = LIMIT_WIDTH'(rpd_pkg::ZERO_TOTAL_VALUE);
   localparam logic [LIMIT_WIDTH-1:0] SCALE_VALUE = LIMIT_WIDTH'(rpd_pkg::PERCENT_SCALE);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // expected result of one transaction
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] value;
      logic                   clamped;
   } percent_type;

   // one directed stimulus row; fixed rows carry a hand-typed expectation
   typedef struct {
      logic [LIMIT_WIDTH-1:0] limit;
      logic [COUNT_WIDTH-1:0] part;
      logic [COUNT_WIDTH-1:0] total;
      bit                     fixed;
      percent_type            expected;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COUNT_WIDTH-1:0] req_part_count = '0;
   logic [COUNT_WIDTH-1:0] req_total_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LIMIT_WIDTH-1:0] rsp_percent_value;
   logic                   rsp_was_clamped;
   logic                   csr_write_enable = 1'b0;
   logic [LIMIT_WIDTH-1:0] csr_write_data = '0;

   percent_type            pending_percent[$];
   percent_type            oldest_percent;
   dir_row_type            dir_rows[$];
   logic [LIMIT_WIDTH-1:0] active_limit = rpd_pkg::LIMIT_RESET;
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int                     mismatch_count = 0;
   int                     items_sent = 0;
   int                     results_checked = 0;
   int                     clamped_seen = 0;
   int                     zero_totals_sent = 0;
   int                     limit_writes = 0;
   int                     cycle_count = 0;

   rounded_percent_divider #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_part_count   (req_part_count),
      .req_total_count  (req_total_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_percent_value(rsp_percent_value),
      .rsp_was_clamped  (rsp_was_clamped),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // rounded percentage, saturated at the limit
   function automatic percent_type calc_percent(input logic [COUNT_WIDTH-1:0] part,
                                                input logic [COUNT_WIDTH-1:0] total,
                                                input logic [LIMIT_WIDTH-1:0] limit);
      percent_type r;
      logic [63:0] exact;
      if (total == '0) begin
         exact = 64'(rpd_pkg::ZERO_TOTAL_VALUE);
      end else begin
         exact = (64'(part) * 64'(rpd_pkg::PERCENT_SCALE) + 64'(total >> 1))
               / 64'(total);
      end
      if (exact > 64'(limit)) begin
         r.value = limit;
         r.clamped = 1'b1;
      end else begin
         r.value = exact[LIMIT_WIDTH-1:0];
         r.clamped = 1'b0;
      end
      return r;
   endfunction

   task automatic add_row(input logic [LIMIT_WIDTH-1:0] limit,
                          input logic [COUNT_WIDTH-1:0] part,
                          input logic [COUNT_WIDTH-1:0] total,
                          input bit fixed,
                          input logic [LIMIT_WIDTH-1:0] value,
                          input logic clamped);
      dir_row_type row;
      row.limit = limit;
      row.part = part;
      row.total = total;
      row.fixed = fixed;
      row.expected.value = value;
      row.expected.clamped = clamped;
      dir_rows.push_back(row);
   endtask

   // drive one transaction and record what it should return
   task automatic send_pair(input logic [COUNT_WIDTH-1:0] part,
                            input logic [COUNT_WIDTH-1:0] total,
                            input percent_type expected);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_part_count <= part;
      req_total_count <= total;
      do @(posedge clock); while (!req_ready);
      pending_percent.push_back(expected);
      items_sent++;
      if (total == '0) zero_totals_sent++;
   endtask

   // stop sending until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_percent.size() != 0);
   endtask

   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] limit);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_limit = limit;
      limit_writes++;
   endtask

   // random operands, biased toward the clamp and rounding boundaries
   task automatic pick_operands(input logic [LIMIT_WIDTH-1:0] limit,
                                output logic [COUNT_WIDTH-1:0] part,
                                output logic [COUNT_WIDTH-1:0] total);
      int          kind;
      logic [63:0] target;
      logic [31:0] m;
      kind = int'($urandom_range(99));
      if (kind < 25) begin
         part = $urandom;
         total = $urandom;
      end else if (kind < 40) begin
         part = $urandom_range(1000);
         total = $urandom_range(1000);
      end else if (kind < 48) begin
         part = $urandom;
         total = '0;
      end else if (kind < 73) begin
         // part near the value that lands right on the limit
         total = $urandom_range(64, 1);
         target = 64'(limit) * 64'(total) / 64'(rpd_pkg::PERCENT_SCALE);
         part = COUNT_WIDTH'(target + 64'($urandom_range(6)) - 64'd3);
      end else if (kind < 88) begin
         // exactly half a percent, or one count off it, unless part wraps
         m = $urandom_range(32'h00FF_FFFF, 1);
         total = m * 32'd200;
         part = m * (2 * $urandom_range(200) + 1) + $urandom_range(2) - 1;
      end else begin
         part = $urandom;
         total = $urandom_range(255, 1);
      end
   endtask

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_percent.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: value %0d clamped %0b",
                        rsp_percent_value, rsp_was_clamped);
         end else begin
            oldest_percent = pending_percent.pop_front();
            results_checked++;
            if (rsp_was_clamped) clamped_seen++;
            if (rsp_percent_value !== oldest_percent.value ||
                rsp_was_clamped !== oldest_percent.clamped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d clamped %0b, got %0d clamped %0b",
                           oldest_percent.value, oldest_percent.clamped,
                           rsp_percent_value, rsp_was_clamped);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rounded_percent_divider_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [COUNT_WIDTH-1:0] part;
      logic [COUNT_WIDTH-1:0] total;
      logic [LIMIT_WIDTH-1:0] phase_limit;
      percent_type            expected;

      // directed rows: zero total, count extremes, rounding and clamp edges
      add_row(LIMIT_MAX, '0, '0, 1'b1, ZERO_VALUE, 1'b0);
      add_row(LIMIT_MAX, '0, 32'd1, 1'b1, '0, 1'b0);
      add_row(LIMIT_MAX, COUNT_MAX, COUNT_MAX, 1'b1, SCALE_VALUE, 1'b0);
      add_row(LIMIT_MAX, COUNT_MAX, 32'd1, 1'b1, LIMIT_MAX, 1'b1);
      add_row(LIMIT_MAX, COUNT_MAX, '0, 1'b1, ZERO_VALUE, 1'b0);
      add_row(LIMIT_MAX, '0, COUNT_MAX, 1'b1, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd1, COUNT_MAX, 1'b1, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd1, 32'd2, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd1, 32'd3, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd2, 32'd3, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd1, 32'd200, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd1, 32'd201, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd21474836, 32'd1, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd21474837, 32'd1, 1'b0, '0, 1'b0);
      add_row(LIMIT_MAX, 32'd42949672, 32'd2, 1'b0, '0, 1'b0);
      add_row('0, '0, '0, 1'b1, '0, 1'b1);
      add_row('0, '0, 32'd5, 1'b1, '0, 1'b0);
      add_row('0, 32'd1, 32'd1, 1'b1, '0, 1'b1);
      add_row(31'd100, '0, '0, 1'b1, ZERO_VALUE, 1'b0);
      add_row(31'd100, COUNT_MAX, COUNT_MAX, 1'b1, SCALE_VALUE, 1'b0);
      add_row(31'd100, 32'd201, 32'd200, 1'b0, '0, 1'b0);
      add_row(31'd99, '0, '0, 1'b1, 31'd99, 1'b1);
      add_row(31'd99, 32'd199, 32'd200, 1'b0, '0, 1'b0);
      add_row(31'd99, 32'd197, 32'd199, 1'b0, '0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (dir_rows[i]) begin
         if (dir_rows[i].limit != active_limit) write_limit(dir_rows[i].limit);
         if (dir_rows[i].fixed) expected = dir_rows[i].expected;
         else expected = calc_percent(dir_rows[i].part, dir_rows[i].total, active_limit);
         send_pair(dir_rows[i].part, dir_rows[i].total, expected);
      end

      // random phases: a limit write each, idling mix set per phase group
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_limit = LIMIT_MAX;
            1: phase_limit = '0;
            2: phase_limit = LIMIT_WIDTH'($urandom);
            3: phase_limit = SCALE_VALUE;
            4: phase_limit = LIMIT_WIDTH'($urandom_range(20000, 1));
            5: phase_limit = LIMIT_MAX - 31'd1;
            6: phase_limit = LIMIT_WIDTH'($urandom_range(1000000, 101));
            default: phase_limit = LIMIT_MAX;
         endcase
         write_limit(phase_limit);
         if (phase < 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 52;
         end else if (phase < 6) begin
            send_idle_pct = 52;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // in phase 1, hold off once mid-phase until the pipeline is empty
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_for_results();
            pick_operands(active_limit, part, total);
            send_pair(part, total, calc_percent(part, total, active_limit));
         end
      end

      // drain, then watch for stray results
      wait_for_results();
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      if (pending_percent.size() != 0) begin
         mismatch_count += pending_percent.size();
         $display("%0d results never arrived", pending_percent.size());
      end

      $display("sent %0d transactions (%0d with zero total) under %0d limit writes",
               items_sent, zero_totals_sent, limit_writes);
      $display("checked %0d results, %0d clamped, %0d mismatches",
               results_checked, clamped_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("rounded_percent_divider_tb: done, clean");
      end else begin
         $display("rounded_percent_divider_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: rounded_percent_divider.f
+incdir+sv
sv/rpd_pkg.sv
sv/rpd_prep.sv
sv/rpd_div_stage.sv
sv/rpd_clamp.sv
sv/rounded_percent_divider.sv
sim/rounded_percent_divider_tb.sv
